FILE: design/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants, types and the elaboration-time gamma threshold table for
// the breathing light ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

  // Ramp and duty scaling
  localparam int LEVEL_MAX = 4095;
  localparam int DUTY_MAX  = 100;

  // Field and state widths
  localparam int LEVEL_W = 13;
  localparam int STEP_W  = 12;
  localparam int DUTY_W  = 7;
  localparam int STATE_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int DUTY_FULL_W = $clog2(DUTY_MAX + 1);

  // Width of the exact integer arithmetic used to build the table
  localparam int BIG_W = 192;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FAST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SLOW = CFG_IDX_W'(1);

  // Configuration reset values
  localparam logic [STEP_W-1:0] STEP_FAST_RST = STEP_W'(40);
  localparam logic [STEP_W-1:0] STEP_SLOW_RST = STEP_W'(16);

  // System state codes
  localparam logic [STATE_W-1:0] ST_STARTING  = STATE_W'(0);
  localparam logic [STATE_W-1:0] ST_RUNNING   = STATE_W'(1);
  localparam logic [STATE_W-1:0] ST_ERROR     = STATE_W'(2);
  localparam logic [STATE_W-1:0] ST_PAUSED    = STATE_W'(3);
  localparam logic [STATE_W-1:0] ST_POWER_OFF = STATE_W'(4);

  // One result word
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              duty_changed;
    logic              falling;
  } brl_result_t;

  // Threshold table: entry d is the lowest level whose duty is at least d
  typedef logic [DUTY_MAX:1][LEVEL_W-1:0] brl_thr_table_t;

  // Raise base to the n-th power in wide integer arithmetic
  function automatic logic [BIG_W-1:0] big_pow(input int unsigned base, input int n);
    logic [BIG_W-1:0] acc;
    int               i;
    acc = BIG_W'(1);
    for (i = 0; i < n; i++) begin
      acc = acc * BIG_W'(base);
    end
    return acc;
  endfunction

  // Smallest level L with L^11 * DUTY_MAX^5 >= d^5 * LEVEL_MAX^11
  function automatic logic [LEVEL_W-1:0] gamma_threshold(input int unsigned d);
    logic [BIG_W-1:0] target;
    logic [BIG_W-1:0] probe;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    int               k;
    target = big_pow(d, 5) * big_pow(LEVEL_MAX, 11);
    lo = 1;
    hi = LEVEL_MAX;
    for (k = 0; k < LEVEL_W + 1; k++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        probe = big_pow(mid, 11) * big_pow(DUTY_MAX, 5);
        if (probe >= target) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return LEVEL_W'(lo);
  endfunction

  // Build the whole threshold table
  function automatic brl_thr_table_t gamma_table();
    brl_thr_table_t tbl;
    int             d;
    for (d = 1; d <= DUTY_MAX; d++) begin
      tbl[d] = gamma_threshold(d);
    end
    return tbl;
  endfunction

  localparam brl_thr_table_t GAMMA_THR = gamma_table();

endpackage

`default_nettype wire

FILE: design/brl_gamma.sv
// ----------------------------------------------------------------------------
// brl_gamma
// Gamma-corrected duty for a ramp level: the level is compared against every
// duty threshold at once and the edge of the resulting thermometer code is
// encoded into the duty value.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_gamma (
  input  wire logic [brl_pkg::LEVEL_W-1:0] level,
  output logic      [brl_pkg::DUTY_W-1:0]  duty
);
  import brl_pkg::*;

  logic [DUTY_MAX+1:1]     therm;
  logic [DUTY_FULL_W-1:0]  duty_full;

  // Compare the level against each threshold
  always_comb begin
    therm = '0;
    for (int d = 1; d <= DUTY_MAX; d++) begin
      therm[d] = (level >= GAMMA_THR[d]);
    end
  end

  // Encode the thermometer edge; levels above the top threshold give DUTY_MAX
  always_comb begin
    duty_full = '0;
    for (int d = 1; d <= DUTY_MAX; d++) begin
      if (therm[d] && !therm[d+1]) begin
        duty_full = duty_full | DUTY_FULL_W'(d);
      end
    end
  end

  // Keep the low duty bits
  assign duty = DUTY_W'(duty_full);

endmodule

`default_nettype wire

FILE: design/brl_ramp.sv
// ----------------------------------------------------------------------------
// brl_ramp
// Step registers, ramp level and direction, last written duty, and the
// per-tick level update for each system state.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_ramp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [brl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brl_pkg::STEP_W-1:0]    cfg_data,
  input  wire logic                          accept,
  input  wire logic [brl_pkg::STATE_W-1:0]   system_state,
  input  wire logic                          skip_starting,
  input  wire logic [brl_pkg::DUTY_W-1:0]    duty,
  output logic      [brl_pkg::LEVEL_W-1:0]   level,
  output brl_pkg::brl_result_t               result
);
  import brl_pkg::*;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX_L = LEVEL_W'(LEVEL_MAX);

  logic [STEP_W-1:0]  step_fast;
  logic [STEP_W-1:0]  step_slow;
  logic               falling;
  logic [DUTY_W-1:0]  last_duty;

  logic               fast;
  logic               pause;
  logic [STEP_W-1:0]  tri_step;
  logic [LEVEL_W:0]   sum_full;
  logic [LEVEL_W-1:0] level_add;
  logic [LEVEL_W-1:0] level_sub;
  logic [LEVEL_W-1:0] level_next;
  logic               falling_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_fast <= STEP_FAST_RST;
      step_slow <= STEP_SLOW_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_FAST: step_fast <= cfg_data;
        REG_STEP_SLOW: step_slow <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the breathe mode and pick the step
  assign fast = (system_state == ST_STARTING) ||
                ((system_state inside {ST_RUNNING, ST_ERROR}) && skip_starting);
  assign pause    = (system_state == ST_PAUSED);
  assign tri_step = fast ? step_fast : step_slow;

  // Add may overshoot LEVEL_MAX; subtract saturates at zero
  assign sum_full  = {1'b0, level} + (LEVEL_W + 1)'(tri_step);
  assign level_add = sum_full[LEVEL_W-1:0];
  assign level_sub = (level > LEVEL_W'(tri_step)) ? (level - LEVEL_W'(tri_step)) : '0;

  // Advance the ramp for this tick
  always_comb begin
    level_next   = level;
    falling_next = falling;
    if (fast || pause) begin
      if (!falling) begin
        if (level < LEVEL_MAX_L) begin
          level_next = level_add;
        end else begin
          level_next   = LEVEL_MAX_L;
          falling_next = 1'b1;
        end
      end else begin
        if (level != '0) begin
          level_next = level_sub;
        end else begin
          falling_next = 1'b0;
        end
      end
    end else if (system_state == ST_POWER_OFF) begin
      if (level != '0) begin
        level_next = level_sub;
      end else begin
        falling_next = 1'b0;
      end
    end else begin
      if (level < LEVEL_MAX_L) begin
        level_next = level_add;
      end else begin
        level_next = LEVEL_MAX_L;
      end
    end
  end

  // Hold ramp state between accepted ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      falling   <= 1'b0;
      last_duty <= '0;
    end else if (accept) begin
      level     <= level_next;
      falling   <= falling_next;
      last_duty <= duty;
    end
  end

  // Form the result word
  assign result.duty         = duty;
  assign result.duty_changed = (duty != last_duty);
  assign result.falling      = falling_next;

endmodule

`default_nettype wire

FILE: design/brl_out_buf.sv
// ----------------------------------------------------------------------------
// brl_out_buf
// Two-word output buffer: an output register plus a skid register, so a new
// word is taken while one finished word waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire brl_pkg::brl_result_t push_data,
  output logic                      can_push,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output brl_pkg::brl_result_t      out_data
);
  import brl_pkg::*;

  brl_result_t skid_data;
  logic        skid_valid;
  logic        take;

  assign take     = out_valid && out_ready;
  assign can_push = !skid_valid;

  // Track occupancy of both registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Move payload words
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/breathing_light_ramp_core.sv
// ----------------------------------------------------------------------------
// breathing_light_ramp_core
// Breathing light ramp: gamma-corrected PWM duty per tick and ramp update.
// ----------------------------------------------------------------------------
// Each accepted word is one tick. The block returns the gamma-corrected duty
// for the ramp level held before the tick, a strobe when that duty differs
// from the previous one, and the ramp direction after the tick's update.
// One tick is taken every clock cycle while in_ready is high; its result goes
// to the output register, or to the skid register while a word waits there.
// The duty comes from comparing the level against a table of per-duty
// thresholds built at elaboration, combinationally and in parallel with the
// level update. A two-word output buffer keeps input ready high while one
// result waits downstream. The user writes the step registers through the cfg
// port only while no tick is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module breathing_light_ramp_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [brl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brl_pkg::STEP_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [brl_pkg::STATE_W-1:0]   system_state,
  input  wire logic                          skip_starting,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [brl_pkg::DUTY_W-1:0]    duty,
  output logic                               duty_changed,
  output logic                               falling
);
  import brl_pkg::*;

  logic [LEVEL_W-1:0] level;
  logic [DUTY_W-1:0]  cur_duty;
  logic               accept;
  brl_result_t        result;
  brl_result_t        out_data;

  assign accept = in_valid && in_ready;

  // Duty lookup for the current level
  brl_gamma u_gamma (
    .level (level),
    .duty  (cur_duty)
  );

  // Ramp state and update
  brl_ramp u_ramp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .system_state  (system_state),
    .skip_starting (skip_starting),
    .duty          (cur_duty),
    .level         (level),
    .result        (result)
  );

  // Result buffering
  brl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign duty         = out_data.duty;
  assign duty_changed = out_data.duty_changed;
  assign falling      = out_data.falling;

endmodule

`default_nettype wire

FILE: sim/brl_checker.sv
// ----------------------------------------------------------------------------
// brl_checker
// Watches the breathing light ramp channels, predicts each result word from
// its own copy of the ramp state and the step registers, and compares.
// ----------------------------------------------------------------------------
module brl_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [brl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brl_pkg::STEP_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [brl_pkg::STATE_W-1:0]   system_state,
  input  wire logic                          skip_starting,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [brl_pkg::DUTY_W-1:0]    duty,
  input  wire logic                          duty_changed,
  input  wire logic                          falling,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 ticks_seen,
  output int                                 words_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import brl_pkg::*;

  // Predicted step registers and ramp state
  logic [STEP_W-1:0]  fast_step;
  logic [STEP_W-1:0]  slow_step;
  logic [LEVEL_W-1:0] ramp_lvl;
  logic               dimming;
  logic [DUTY_W-1:0]  prev_duty;

  // Duty per level below full scale, masked to the port width
  logic [DUTY_W-1:0]  duty_of_level [0:LEVEL_MAX-1];

  brl_result_t        expected_words [$];

  // Build the duty table: largest d with d^5 * LEVEL_MAX^11 <= L^11 * DUTY_MAX^5
  initial begin : build_duty_table
    logic [191:0] duty_pow5;
    logic [191:0] lvl_pow11;
    logic [191:0] full_pow11;
    logic [191:0] rhs;
    logic [191:0] lhs;
    int           d;
    int           lv;
    int           k;
    duty_pow5 = 192'd1;
    full_pow11 = 192'd1;
    for (k = 0; k < 5; k++) duty_pow5 = duty_pow5 * 192'(DUTY_MAX);
    for (k = 0; k < 11; k++) full_pow11 = full_pow11 * 192'(LEVEL_MAX);
    d = 0;
    duty_of_level[0] = '0;
    for (lv = 1; lv < LEVEL_MAX; lv++) begin
      lvl_pow11 = 192'd1;
      for (k = 0; k < 11; k++) lvl_pow11 = lvl_pow11 * 192'(lv);
      rhs = lvl_pow11 * duty_pow5;
      // duty is monotone in level, so only walk upward
      while (d < DUTY_MAX - 1) begin
        lhs = 192'd1;
        for (k = 0; k < 5; k++) lhs = lhs * 192'(d + 1);
        lhs = lhs * full_pow11;
        if (lhs <= rhs) begin
          d++;
        end else begin
          break;
        end
      end
      duty_of_level[lv] = DUTY_W'(d);
    end
  end

  // Triangle breathe: climb to full scale, turn, fall to zero, turn
  task automatic breathe_triangle(input logic [STEP_W-1:0] step);
    if (!dimming) begin
      if (ramp_lvl < LEVEL_MAX) begin
        ramp_lvl = ramp_lvl + LEVEL_W'(step);
      end else begin
        ramp_lvl = LEVEL_W'(LEVEL_MAX);
        dimming = 1'b1;
      end
    end else begin
      if (ramp_lvl > 0) begin
        ramp_lvl = (ramp_lvl > step) ? ramp_lvl - LEVEL_W'(step) : '0;
      end else begin
        dimming = 1'b0;
      end
    end
  endtask

  // Work out the result word for one tick and advance the ramp
  task automatic predict_tick(input logic [STATE_W-1:0] st, input logic skip);
    brl_result_t word;
    logic        fast_breathe;
    word.duty = (ramp_lvl >= LEVEL_MAX) ? DUTY_W'(DUTY_MAX)
                                        : duty_of_level[ramp_lvl[LEVEL_W-2:0]];
    word.duty_changed = (word.duty != prev_duty);
    prev_duty = word.duty;
    fast_breathe = (st == ST_STARTING) || (((st == ST_RUNNING) || (st == ST_ERROR)) && skip);
    if (fast_breathe) begin
      breathe_triangle(fast_step);
    end else if (st == ST_PAUSED) begin
      breathe_triangle(slow_step);
    end else if (st == ST_POWER_OFF) begin
      // fade down, saturating at zero
      if (ramp_lvl > 0) begin
        ramp_lvl = (ramp_lvl > slow_step) ? ramp_lvl - LEVEL_W'(slow_step) : '0;
      end else begin
        dimming = 1'b0;
      end
    end else begin
      // fade up and hold; an overshoot is clamped on the next tick
      if (ramp_lvl < LEVEL_MAX) begin
        ramp_lvl = ramp_lvl + LEVEL_W'(slow_step);
      end else begin
        ramp_lvl = LEVEL_W'(LEVEL_MAX);
      end
    end
    word.falling = dimming;
    expected_words.push_back(word);
  endtask

  // Sample both channels and the register port at each rising edge
  always @(posedge clk) begin : watch_channels
    brl_result_t want;
    if (rst) begin
      fast_step = STEP_FAST_RST;
      slow_step = STEP_SLOW_RST;
      ramp_lvl = '0;
      dimming = 1'b0;
      prev_duty = '0;
      expected_words.delete();
      fail_count = 0;
      ticks_seen = 0;
      words_checked = 0;
    end else begin
      // check the outgoing word against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: duty %0d duty_changed %0d falling %0d",
                 duty, duty_changed, falling);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, duty);
            fail_count++;
          end
          if (duty_changed !== want.duty_changed) begin
            $error("duty_changed: expected %0d, got %0d", want.duty_changed, duty_changed);
            fail_count++;
          end
          if (falling !== want.falling) begin
            $error("falling: expected %0d, got %0d", want.falling, falling);
            fail_count++;
          end
          words_checked++;
        end
      end
      // track step register writes; other indexes are dropped
      if (cfg_write) begin
        case (cfg_index)
          REG_STEP_FAST: begin
            fast_step = cfg_data;
          end
          REG_STEP_SLOW: begin
            slow_step = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        predict_tick(system_state, skip_starting);
        ticks_seen++;
      end
    end
    pending = expected_words.size();
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Breathing light ramp testbench: directed ticks over every system state,
// then random runs of held states under several step settings and idle mixes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brl_pkg::*;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  // First of the state codes treated as "other"
  localparam logic [STATE_W-1:0]   ST_OTHER    = STATE_W'(5);
  localparam int RANDOM_TICKS = 1125;
  localparam int PHASES       = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_FAST;
  logic [STEP_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [STATE_W-1:0]   system_state = ST_STARTING;
  logic                 skip_starting = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DUTY_W-1:0]    duty;
  logic                 duty_changed;
  logic                 falling;

  int fail_count;
  int pending;
  int ticks_seen;
  int words_checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int step_settings = 1;

  breathing_light_ramp_core u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .system_state(system_state), .skip_starting(skip_starting),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty(duty), .duty_changed(duty_changed), .falling(falling)
  );

  brl_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .system_state(system_state), .skip_starting(skip_starting),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty(duty), .duty_changed(duty_changed), .falling(falling),
    .fail_count(fail_count), .pending(pending),
    .ticks_seen(ticks_seen), .words_checked(words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready = rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Offer one tick word, idling first at random; return after it is taken
  task automatic send_tick(input logic [STATE_W-1:0] st, input logic skip);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    system_state = st;
    skip_starting = skip;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted word has come back
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_steps(input logic [STEP_W-1:0] fast, input logic [STEP_W-1:0] slow);
    write_reg(REG_STEP_FAST, fast);
    write_reg(REG_STEP_SLOW, slow);
    step_settings++;
  endtask

  // Timeout guard
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int                 ph;
    int                 sent;
    int                 run_len;
    int                 pick;
    int                 k;
    int                 s;
    logic [STATE_W-1:0] st;
    logic               skip;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: every state code with both skip values at reset steps
    for (s = 0; s < 8; s++) begin
      send_tick(STATE_W'(s), 1'b0);
      send_tick(STATE_W'(s), 1'b1);
    end
    // Directed: full-scale step forces overshoot, clamp, turn and fade to zero
    drain();
    set_steps(STEP_W'(4095), STEP_SLOW_RST);
    for (k = 0; k < 3; k++) send_tick(ST_STARTING, 1'b0);
    send_tick(ST_PAUSED, 1'b0);
    send_tick(ST_PAUSED, 1'b1);
    for (k = 0; k < 3; k++) send_tick(ST_POWER_OFF, 1'b0);
    send_tick(ST_OTHER, 1'b1);

    // Random runs of held states, one step setting and idle mix per phase
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: set_steps(STEP_FAST_RST, STEP_SLOW_RST);
        1: set_steps(STEP_W'(4095), STEP_W'(4095));
        2: set_steps(STEP_W'(1), STEP_W'(1));
        3: set_steps('0, STEP_W'($urandom_range(1, 200)));
        4: set_steps(STEP_W'(4095), STEP_W'(1));
        5: set_steps(STEP_W'(1), STEP_W'(4095));
        6: set_steps(STEP_W'($urandom_range(1, 600)), STEP_W'($urandom_range(1, 300)));
        default: set_steps(STEP_W'($urandom_range(1, 4095)), '0);
      endcase
      // spare indexes must leave the steps alone
      write_reg(REG_SPARE_A, STEP_W'($urandom));
      write_reg(REG_SPARE_B, STEP_W'($urandom));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      sent = 0;
      while (sent < RANDOM_TICKS / PHASES) begin
        // choose the state to hold for this run
        pick = $urandom_range(99);
        skip = 1'($urandom);
        if (pick < 20) begin
          st = ST_STARTING;
        end else if (pick < 40) begin
          st = ($urandom_range(1) != 0) ? ST_RUNNING : ST_ERROR;
          skip = 1'b1;
        end else if (pick < 60) begin
          st = ST_PAUSED;
        end else if (pick < 75) begin
          st = ST_POWER_OFF;
        end else begin
          pick = $urandom_range(4);
          if (pick == 0) begin
            st = ST_RUNNING;
            skip = 1'b0;
          end else if (pick == 1) begin
            st = ST_ERROR;
            skip = 1'b0;
          end else begin
            st = ST_OTHER + STATE_W'(pick - 2);
          end
        end
        run_len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        for (k = 0; k < run_len && sent < RANDOM_TICKS / PHASES; k++) begin
          // a few stray ticks break the run
          if ($urandom_range(99) < 4) begin
            send_tick(STATE_W'($urandom), 1'($urandom));
          end else begin
            send_tick(st, skip);
          end
          sent++;
        end
        if ($urandom_range(15) == 0) begin
          in_valid = 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end

    // Wait out the last results, then give the verdict
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d ticks and %0d result words over %0d step settings,",
             ticks_seen, words_checked, step_settings);
    $display("every state code, zero and full-scale steps, and four idle/stall mixes.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
design/brl_pkg.sv
design/brl_gamma.sv
design/brl_ramp.sv
design/brl_out_buf.sv
design/breathing_light_ramp_core.sv
sim/brl_checker.sv
sim/tb.sv
